### design/rtcu_pkg.sv
// ---------------------------------------------------------------------------
// rtcu_pkg: shared types and constants for the RTC calendar update block
// Calendar time record, command and divider codes, leap year and month
// length helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package rtcu_pkg;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_LOAD   = 1'b1
    } t_op;

    typedef enum logic {
        DIV_BY_60 = 1'b0,
        DIV_BY_24 = 1'b1
    } t_div_sel;

    typedef struct packed {
        logic     start;
        t_div_sel sel;
    } t_div_req;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_time;

    localparam int TIME_W = $bits(t_time);

    localparam logic [5:0]  SEC_PER_MIN     = 6'd60;
    localparam logic [5:0]  MIN_PER_HOUR    = 6'd60;
    localparam logic [4:0]  HOUR_PER_DAY    = 5'd24;
    localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;
    localparam logic [11:0] RESET_YEAR      = 12'd2000;

    // Exact floor(y / 25) for every multiple of 25 below 4096.
    localparam logic [10:0] RECIP_25       = 11'd1311;
    localparam int          RECIP_25_SHIFT = 15;

    localparam t_time RESET_TIME = '{
        year:   RESET_YEAR,
        month:  4'd1,
        day:    5'd1,
        hour:   5'd0,
        minute: 6'd0,
        second: 6'd0
    };

    function automatic logic [5:0] div_value(input t_div_sel sel);
        logic [5:0] d;
        case (sel)
            DIV_BY_60: d = SEC_PER_MIN;
            DIV_BY_24: d = {1'b0, HOUR_PER_DAY};
            default:   d = SEC_PER_MIN;
        endcase
        return d;
    endfunction

    // Divisible by 100 is divisible by 4 and 25; by 400 is by 16 and 25.
    function automatic logic is_leap(input logic [11:0] year);
        logic [22:0] prod;
        logic [7:0]  q25;
        logic [11:0] back25;
        logic        div4;
        logic        div16;
        logic        div25;
        prod   = 23'(year) * 23'(RECIP_25);
        q25    = 8'(prod >> RECIP_25_SHIFT);
        back25 = 12'(q25) * 12'd25;
        div4   = (year[1:0] == 2'd0);
        div16  = (year[3:0] == 4'd0);
        div25  = (back25 == year);
        return (div4 && !div25) || (div16 && div25);
    endfunction

    // Months outside one to twelve are treated as long months.
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

### design/rtcu_fifo.sv
// ---------------------------------------------------------------------------
// rtcu_fifo: command queue between front and back
// Two-entry first-in first-out queue of packed command words.
// ---------------------------------------------------------------------------
`default_nettype none

module rtcu_fifo #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    output logic              o_valid,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data
);
    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CNT_W'(DEPTH)))
        else $error("word pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("word popped from an empty queue");

endmodule

`default_nettype wire

### design/rtcu_front.sv
// ---------------------------------------------------------------------------
// rtcu_front: input side of the RTC calendar update
// Accepts words, tracks the last counter reading and turns an update into
// a count of whole seconds before queuing it.
// ---------------------------------------------------------------------------
`default_nettype none

module rtcu_front #(
    parameter int COUNT_WIDTH = 24,
    parameter int TICK_SHIFT  = 8,
    parameter int SW          = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic                   i_opcode,
    input  wire logic [COUNT_WIDTH-1:0] i_counter_value,
    input  wire logic [5:0]             i_load_second,
    input  wire logic [5:0]             i_load_minute,
    input  wire logic [4:0]             i_load_hour,
    input  wire logic [4:0]             i_load_day,
    input  wire logic [3:0]             i_load_month,
    input  wire logic [11:0]            i_load_year,
    input  wire logic                   i_full,
    output logic                        o_push,
    output rtcu_pkg::t_op               o_op,
    output logic [SW-1:0]               o_secs,
    output rtcu_pkg::t_time             o_load
);
    import rtcu_pkg::*;

    logic [COUNT_WIDTH-1:0] r_last_count;
    logic [COUNT_WIDTH-1:0] delta;
    logic [COUNT_WIDTH-1:0] whole;

    // The subtraction wraps at the counter width, so a reading below the
    // previous one counts across the wrap.
    assign delta = i_counter_value - r_last_count;
    assign whole = delta >> TICK_SHIFT;

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;
    assign o_op       = t_op'(i_opcode);
    assign o_secs     = whole[SW-1:0];
    assign o_load     = '{
        year:   i_load_year,
        month:  i_load_month,
        day:    i_load_day,
        hour:   i_load_hour,
        minute: i_load_minute,
        second: i_load_second
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_count <= '0;
        end else if (o_push && (o_op == OP_UPDATE)) begin
            r_last_count <= i_counter_value;
        end
    end

endmodule

`default_nettype wire

### design/rtcu_div.sv
// ---------------------------------------------------------------------------
// rtcu_div: shared divider by sixty or twenty-four
// Registers the dividend, then forms the quotient in the next cycle by
// multiplying with a rounded-up reciprocal; the remainder follows from the
// low bits of the dividend and of the quotient times the divisor.
// ---------------------------------------------------------------------------
`default_nettype none

module rtcu_div #(
    parameter int DW = 18
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  rtcu_pkg::t_div_req     i_req,
    input  wire logic [DW-1:0]     i_dividend,
    output logic                   o_done,
    output logic [DW-1:0]          o_quot,
    output logic [5:0]             o_rem
);
    import rtcu_pkg::*;

    // With the shift six bits beyond the dividend width, the rounded-up
    // reciprocal of either divisor gives the exact quotient for every dividend.
    localparam int K  = DW + 6;
    localparam int MW = DW + 2;
    localparam int PW = DW + MW;

    localparam logic [MW-1:0] RECIP_60 =
        MW'(((64'd1 << K) + 64'(SEC_PER_MIN) - 64'd1) / 64'(SEC_PER_MIN));
    localparam logic [MW-1:0] RECIP_24 =
        MW'(((64'd1 << K) + 64'(HOUR_PER_DAY) - 64'd1) / 64'(HOUR_PER_DAY));

    logic          r_busy;
    logic          r_done;
    t_div_sel      r_sel;
    logic [DW-1:0] r_x;
    logic [DW-1:0] r_quot;

    logic [MW-1:0] recip;
    logic [PW-1:0] prod;
    logic [5:0]    d;
    logic [5:0]    qd_lo;

    assign recip = (r_sel == DIV_BY_24) ? RECIP_24 : RECIP_60;
    assign prod  = PW'(r_x) * PW'(recip);
    assign d     = div_value(r_sel);

    // The remainder is below sixty-four, so six bits of the product suffice.
    assign qd_lo = r_quot[5:0] * d;

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_x[5:0] - qd_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_req.start;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= i_dividend;
            r_sel <= i_req.sel;
        end
        if (r_busy) begin
            r_quot <= DW'(prod >> K);
        end
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (o_rem < d))
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

### design/rtcu_back.sv
// ---------------------------------------------------------------------------
// rtcu_back: calendar sequencer of the RTC calendar update
// Holds the calendar time or loads a new one, carries seconds into minutes,
// hours and days through the shared divider, steps days one per cycle and
// registers the result word.
// ---------------------------------------------------------------------------
`default_nettype none

module rtcu_back #(
    parameter int SW = 16,
    parameter int DW = 18
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_pop,
    input  rtcu_pkg::t_op       i_cmd_op,
    input  wire logic [SW-1:0]  i_cmd_secs,
    input  rtcu_pkg::t_time     i_cmd_load,
    output rtcu_pkg::t_div_req  o_div_req,
    output logic [DW-1:0]       o_div_dividend,
    input  wire logic           i_div_done,
    input  wire logic [DW-1:0]  i_div_quot,
    input  wire logic [5:0]     i_div_rem,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output rtcu_pkg::t_time     o_out_time
);
    import rtcu_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SEC  = 6'b000010,
        S_MIN  = 6'b000100,
        S_HOUR = 6'b001000,
        S_DAY  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    localparam logic [DW-1:0] MIN_BIAS  = DW'(MIN_PER_HOUR - 6'd1);
    localparam logic [DW-1:0] HOUR_BIAS = DW'(HOUR_PER_DAY - 5'd1);

    t_state        r_state;
    t_state        n_state;
    t_time         r_time;
    t_time         n_time;
    logic [DW-1:0] r_days;
    logic [DW-1:0] n_days;
    logic          r_out_valid;
    t_time         r_out;
    logic          out_load;

    logic [DW-1:0] min_sum;
    logic [DW-1:0] hour_sum;
    logic [5:0]    day_inc;
    logic [4:0]    mon_inc;
    logic [4:0]    cur_len;

    // A minute or hour already past its limit wraps to zero on the first
    // carry; adding limit minus one gives that carry plus the rest.
    assign min_sum  = (r_time.minute >= MIN_PER_HOUR) ? (i_div_quot + MIN_BIAS)
                                                      : (i_div_quot + DW'(r_time.minute));
    assign hour_sum = (r_time.hour >= HOUR_PER_DAY) ? (i_div_quot + HOUR_BIAS)
                                                    : (i_div_quot + DW'(r_time.hour));

    assign day_inc = {1'b0, r_time.day} + 6'd1;
    assign mon_inc = {1'b0, r_time.month} + 5'd1;
    assign cur_len = month_len(r_time.month, is_leap(r_time.year));

    assign out_load    = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_time  = r_out;

    always_comb begin
        n_state        = r_state;
        n_time         = r_time;
        n_days         = r_days;
        o_cmd_pop      = 1'b0;
        o_div_req      = '{start: 1'b0, sel: DIV_BY_60};
        o_div_dividend = '0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd_op == OP_LOAD) begin
                        n_time  = i_cmd_load;
                        n_state = S_OUT;
                    end else begin
                        o_div_req      = '{start: 1'b1, sel: DIV_BY_60};
                        o_div_dividend = DW'(i_cmd_secs) + DW'(r_time.second);
                        n_state        = S_SEC;
                    end
                end
            end
            S_SEC: begin
                if (i_div_done) begin
                    n_time.second = i_div_rem;
                    if (i_div_quot == '0) begin
                        n_state = S_OUT;
                    end else begin
                        o_div_req      = '{start: 1'b1, sel: DIV_BY_60};
                        o_div_dividend = min_sum;
                        n_state        = S_MIN;
                    end
                end
            end
            S_MIN: begin
                if (i_div_done) begin
                    n_time.minute = i_div_rem;
                    if (i_div_quot == '0) begin
                        n_state = S_OUT;
                    end else begin
                        o_div_req      = '{start: 1'b1, sel: DIV_BY_24};
                        o_div_dividend = hour_sum;
                        n_state        = S_HOUR;
                    end
                end
            end
            S_HOUR: begin
                if (i_div_done) begin
                    n_time.hour = i_div_rem[4:0];
                    n_days      = i_div_quot;
                    n_state     = (i_div_quot == '0) ? S_OUT : S_DAY;
                end
            end
            S_DAY: begin
                if (day_inc > {1'b0, cur_len}) begin
                    n_time.day = 5'd1;
                    if (mon_inc > {1'b0, MONTHS_PER_YEAR}) begin
                        n_time.month = 4'd1;
                        n_time.year  = r_time.year + 12'd1;
                    end else begin
                        n_time.month = mon_inc[3:0];
                    end
                end else begin
                    n_time.day = day_inc[4:0];
                end
                n_days = r_days - DW'(1);
                if (r_days == DW'(1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_time      <= RESET_TIME;
            r_days      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_time  <= n_time;
            r_days  <= n_days;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_time;
        end
    end

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_done |-> (r_state == S_SEC || r_state == S_MIN || r_state == S_HOUR))
        else $error("divider result arrived outside a carry step");

    a_day_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DAY) |-> (r_days != '0))
        else $error("day stepping with no days left");

endmodule

`default_nettype wire

### design/rtc_calendar_update.sv
// Sequence: a load word's time is registered as the result; an update divides its
// seconds in the shared divider, a minute carry and an hour carry each take a
// further division, and the days are then stepped one at a time.
// Flow: the back sequencer takes one word at a time and pops no new word until
// its result is registered; an output stall holds it in its output step.
// Reset: synchronous, clears the queue and sets 2000-01-01 00:00:00 and count zero.
// ---------------------------------------------------------------------------
// rtc_calendar_update: calendar clock driven by a free-running tick counter
// Front classifies words and forms whole seconds, a two-word queue decouples
// it from the back, which carries the time and returns one result word.
// ---------------------------------------------------------------------------
`default_nettype none

module rtc_calendar_update #(
    parameter int COUNT_WIDTH = 24,
    parameter int TICK_SHIFT  = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic                   i_opcode,
    input  wire logic [COUNT_WIDTH-1:0] i_counter_value,
    input  wire logic [5:0]             i_load_second,
    input  wire logic [5:0]             i_load_minute,
    input  wire logic [4:0]             i_load_hour,
    input  wire logic [4:0]             i_load_day,
    input  wire logic [3:0]             i_load_month,
    input  wire logic [11:0]            i_load_year,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [5:0]                  o_cur_second,
    output logic [5:0]                  o_cur_minute,
    output logic [4:0]                  o_cur_hour,
    output logic [4:0]                  o_cur_day,
    output logic [3:0]                  o_cur_month,
    output logic [11:0]                 o_cur_year
);
    import rtcu_pkg::*;

    localparam int SW = (COUNT_WIDTH > TICK_SHIFT) ? (COUNT_WIDTH - TICK_SHIFT) : 1;
    localparam int TW = ((SW > 6) ? SW : 6) + 1;
    localparam int DW = TW + 1;
    localparam int QW = 1 + SW + TIME_W;

    logic          fifo_full;
    logic          push;
    t_op           front_op;
    logic [SW-1:0] front_secs;
    t_time         front_load;
    logic [QW-1:0] fifo_in;
    logic [QW-1:0] fifo_out;
    logic          cmd_valid;
    logic          cmd_pop;
    t_div_req      div_req;
    logic [DW-1:0] div_dividend;
    logic          div_done;
    logic [DW-1:0] div_quot;
    logic [5:0]    div_rem;
    t_time         out_time;

    rtcu_front #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TICK_SHIFT  (TICK_SHIFT),
        .SW          (SW)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_counter_value (i_counter_value),
        .i_load_second   (i_load_second),
        .i_load_minute   (i_load_minute),
        .i_load_hour     (i_load_hour),
        .i_load_day      (i_load_day),
        .i_load_month    (i_load_month),
        .i_load_year     (i_load_year),
        .i_full          (fifo_full),
        .o_push          (push),
        .o_op            (front_op),
        .o_secs          (front_secs),
        .o_load          (front_load)
    );

    assign fifo_in = {front_op, front_secs, front_load};

    rtcu_fifo #(
        .W (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (fifo_in),
        .o_full  (fifo_full),
        .o_valid (cmd_valid),
        .i_pop   (cmd_pop),
        .o_data  (fifo_out)
    );

    rtcu_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dividend),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    rtcu_back #(
        .SW (SW),
        .DW (DW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (cmd_valid),
        .o_cmd_pop      (cmd_pop),
        .i_cmd_op       (t_op'(fifo_out[QW-1])),
        .i_cmd_secs     (fifo_out[TIME_W +: SW]),
        .i_cmd_load     (t_time'(fifo_out[TIME_W-1:0])),
        .o_div_req      (div_req),
        .o_div_dividend (div_dividend),
        .i_div_done     (div_done),
        .i_div_quot     (div_quot),
        .i_div_rem      (div_rem),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_time     (out_time)
    );

    assign o_cur_second = out_time.second;
    assign o_cur_minute = out_time.minute;
    assign o_cur_hour   = out_time.hour;
    assign o_cur_day    = out_time.day;
    assign o_cur_month  = out_time.month;
    assign o_cur_year   = out_time.year;

endmodule

`default_nettype wire
